FILE: rtl/core/rbf_pkg.sv
// Shared types, constants and exp tables for the RBF SVM classifier core.
`default_nettype none
package rbf_pkg;

    localparam int FEAT_W = 16;
    localparam int WGT_W  = 16;
    localparam int NUM_FEAT = 4;

    typedef enum logic [1:0] {
        CFG_GAMMA  = 2'd0,
        CFG_BIAS   = 2'd1,
        CFG_ACTIVE = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
    } t_dp_status;

    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] v;
        begin
            case (n)
                4'd0:  v = 17'd65536;
                4'd1:  v = 17'd24109;
                4'd2:  v = 17'd8869;
                4'd3:  v = 17'd3263;
                4'd4:  v = 17'd1200;
                4'd5:  v = 17'd442;
                4'd6:  v = 17'd162;
                4'd7:  v = 17'd60;
                4'd8:  v = 17'd22;
                4'd9:  v = 17'd8;
                4'd10: v = 17'd3;
                4'd11: v = 17'd1;
                default: v = 17'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [16:0] exp_frac(input logic [3:0] k);
        logic [16:0] v;
        begin
            case (k)
                4'd0:  v = 17'd65536;
                4'd1:  v = 17'd61565;
                4'd2:  v = 17'd57835;
                4'd3:  v = 17'd54331;
                4'd4:  v = 17'd51039;
                4'd5:  v = 17'd47947;
                4'd6:  v = 17'd45042;
                4'd7:  v = 17'd42313;
                4'd8:  v = 17'd39750;
                4'd9:  v = 17'd37341;
                4'd10: v = 17'd35079;
                4'd11: v = 17'd32954;
                4'd12: v = 17'd30957;
                4'd13: v = 17'd29081;
                4'd14: v = 17'd27319;
                default: v = 17'd25664;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rbf_if.sv
// Valid/ready request channels for the classifier core.
`default_nettype none
interface rbf_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [5:0]  entry_index;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic signed [15:0] weight;
    modport source (output valid, func, entry_index, feature_0, feature_1, feature_2,
                    feature_3, weight, input ready);
    modport sink (input valid, func, entry_index, feature_0, feature_1, feature_2,
                  feature_3, weight, output ready);
endinterface

interface rbf_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] decision_value;
    logic        class_positive;
    modport source (output valid, decision_value, class_positive, input ready);
    modport sink (input valid, decision_value, class_positive, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rbf_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/rbf_ctrl.sv
// Query sequencer: walks the active entries and hands off the result.
`default_nettype none
module rbf_ctrl import rbf_pkg::*; #(
    parameter int MAX_VECTORS = 64
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire [6:0]                     i_active,
    input  wire                           i_out_ready,
    input  wire t_dp_status               i_status,
    output t_dp_cmd                       o_cmd,
    output logic [$clog2(MAX_VECTORS)-1:0] o_addr,
    output logic                          o_idle,
    output logic                          o_out_valid
);
    localparam int AW = $clog2(MAX_VECTORS);
    localparam int CW = $clog2(MAX_VECTORS + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] w_limit;

    always_comb begin
        if ({25'd0, i_active} > 32'(MAX_VECTORS)) begin
            w_limit = CW'(MAX_VECTORS);
        end else begin
            w_limit = CW'(i_active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt >= w_limit) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_idle       = 1'b0;
        o_out_valid  = 1'b0;
        o_addr       = r_cnt[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_idle      = 1'b1;
                o_cmd.clear = i_start;
            end
            ST_RUN:   o_cmd.issue  = (r_cnt < w_limit);
            ST_DRAIN: o_cmd.finish = !i_status.busy;
            ST_OUT:   o_out_valid  = 1'b1;
            default:  o_idle       = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/core/rbf_datapath.sv
// Distance, exp lookup and weighted accumulation pipeline.
`default_nettype none
module rbf_datapath import rbf_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire t_dp_cmd      i_cmd,
    input  wire [3:0]         i_feat_en,
    input  wire [63:0]        i_query,
    input  wire [63:0]        i_sv,
    input  wire [15:0]        i_wgt,
    input  wire [15:0]        i_gamma,
    input  wire signed [31:0] i_bias,
    output t_dp_status        o_status,
    output logic signed [31:0] o_decision
);
    // valid pipe: issue -> ram data -> dist -> arg -> kprod -> kernel -> acc
    logic [4:0] r_vld;
    logic [63:0] r_x;
    logic [35:0] r_dist;
    logic [15:0] r_wgt1, r_wgt2, r_wgt3, r_wgt4;
    logic [51:0] r_arg;
    logic [33:0] r_kprod;
    logic [15:0] r_kern;
    logic signed [43:0] r_acc;
    logic [35:0] w_dist;
    logic [16:0] w_ei, w_ef;
    logic [33:0] w_kp;
    logic [15:0] w_kern;
    logic signed [33:0] w_prod;
    logic signed [43:0] w_rnd;
    logic signed [32:0] w_sum;
    logic signed [33:0] w_dec;
    logic r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_cmd.issue};
        end
    end

    always_comb begin
        w_dist = '0;
        for (int d = 0; d < NUM_FEAT; d++) begin
            logic signed [16:0] df;
            df = 17'(signed'(i_sv[16*d +: 16])) - 17'(signed'(r_x[16*d +: 16]));
            if (i_feat_en[d]) begin
                w_dist = w_dist + 36'(unsigned'(34'(df) * 34'(df)));
            end
        end
    end

    assign w_ei = exp_int(r_arg[19:16]);
    assign w_ef = exp_frac(r_arg[15:12]);
    assign w_kp = 34'(w_ei) * 34'(w_ef) + 34'd32768;
    assign w_kern = (r_kprod[33:16] > 18'd65535) ? 16'hFFFF : r_kprod[31:16];
    assign w_prod = signed'(r_wgt4) * signed'({1'b0, r_kern});
    assign w_rnd  = r_acc + 44'sd2048;
    assign w_sum  = 33'(w_rnd >>> 12);
    assign w_dec  = 34'(w_sum) - 34'(i_bias);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_x <= i_query;
        end
        r_wgt1 <= i_wgt;
        r_dist <= w_dist;
        r_wgt2 <= r_wgt1;
        r_arg  <= ({36'd0, i_gamma} * {16'd0, r_dist}) >> 8;
        r_wgt3 <= r_wgt2;
        r_zero <= (r_arg >= 52'(12 << 16));
        r_kprod <= w_kp;
        r_wgt4 <= r_wgt3;
        r_kern <= r_zero ? 16'd0 : w_kern;
        if (i_cmd.clear) begin
            r_acc <= '0;
        end else if (r_vld[4]) begin
            r_acc <= r_acc + 44'(w_prod);
        end
        if (i_cmd.finish) begin
            if (w_dec > 34'sh7FFFFFFF) begin
                o_decision <= 32'sh7FFFFFFF;
            end else if (w_dec < -34'sh80000000) begin
                o_decision <= 32'sh80000000;
            end else begin
                o_decision <= 32'(w_dec);
            end
        end
    end

    assign o_status.busy = |r_vld;
endmodule
`default_nettype wire

FILE: rtl/core/rbf_kernel_svm_classifier_core.sv
// Top level of the RBF-kernel SVM classifier core.
// Channels: in_req (sink) takes loads (func 0) and queries (func 1);
// out_req (source) returns one decision per query; cfg write port sets
// gamma_scale (0), bias (1) and active_count (2).
// A load writes the vector and weight stores and gives no result. A query
// walks the active entries one per cycle through a registered store read,
// distance, gamma multiply, exp table product, kernel and accumulate
// stages, then waits for the pipeline to drain before it gives its result.
// One query is in flight at a time; input ready is low until its result
// has been taken. The result holds while the receiver stalls.
// Reset clears the controller and loads the register defaults; the stores
// are not cleared and must be loaded before they are used.
`default_nettype none
module rbf_kernel_svm_classifier_core import rbf_pkg::*; #(
    parameter int MAX_VECTORS = 64,
    parameter int DIM = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rbf_in_if.sink      in_req,
    rbf_out_if.source   out_req,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_index,
    input  wire [31:0]  i_cfg_wdata
);
    localparam int AW = $clog2(MAX_VECTORS);

    logic [15:0] r_gamma;
    logic signed [31:0] r_bias;
    logic [6:0] r_active;
    t_dp_cmd w_cmd;
    t_dp_status w_status;
    logic [AW-1:0] w_addr;
    logic w_idle, w_load, w_query;
    logic [63:0] w_feat, w_sv;
    logic [15:0] w_wgt;
    logic [3:0] w_fen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma  <= 16'd128;
            r_bias   <= '0;
            r_active <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAMMA:  r_gamma  <= i_cfg_wdata[15:0];
                CFG_BIAS:   r_bias   <= i_cfg_wdata;
                CFG_ACTIVE: r_active <= i_cfg_wdata[6:0];
                default:    r_gamma  <= r_gamma;
            endcase
        end
    end

    assign in_req.ready = w_idle;
    assign w_load  = in_req.valid && w_idle && !in_req.func &&
                     ({26'd0, in_req.entry_index} < 32'(MAX_VECTORS));
    assign w_query = in_req.valid && w_idle && in_req.func;
    assign w_feat  = {in_req.feature_3, in_req.feature_2, in_req.feature_1,
                      in_req.feature_0};

    always_comb begin
        for (int d = 0; d < NUM_FEAT; d++) begin
            w_fen[d] = (d < DIM);
        end
    end

    rbf_ram #(.WIDTH(64), .DEPTH(MAX_VECTORS)) u_vec (
        .i_clk(i_clk), .i_we(w_load), .i_waddr(AW'(in_req.entry_index)),
        .i_wdata(w_feat), .i_raddr(w_addr), .o_rdata(w_sv)
    );

    rbf_ram #(.WIDTH(16), .DEPTH(MAX_VECTORS)) u_wgt (
        .i_clk(i_clk), .i_we(w_load), .i_waddr(AW'(in_req.entry_index)),
        .i_wdata(in_req.weight), .i_raddr(w_addr), .o_rdata(w_wgt)
    );

    rbf_ctrl #(.MAX_VECTORS(MAX_VECTORS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_query), .i_active(r_active),
        .i_out_ready(out_req.ready), .i_status(w_status), .o_cmd(w_cmd),
        .o_addr(w_addr), .o_idle(w_idle), .o_out_valid(out_req.valid)
    );

    rbf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_feat_en(w_fen),
        .i_query(w_feat), .i_sv(w_sv), .i_wgt(w_wgt), .i_gamma(r_gamma),
        .i_bias(r_bias), .o_status(w_status), .o_decision(out_req.decision_value)
    );

    assign out_req.class_positive = !out_req.decision_value[31];

    a_no_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_req.valid |-> !in_req.ready)
        else $error("input ready while result pending");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_req.valid && !out_req.ready |=> out_req.valid && $stable(out_req.decision_value))
        else $error("result changed under stall");
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req.valid && in_req.ready && in_req.func |=> !in_req.ready)
        else $error("query did not start");
endmodule
`default_nettype wire
